### rtl/cclrn_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cclrn_pkg: shared types and constants for cross-channel LRN
// Configuration, job and state types, count limits and the 2^-(2^-i) table.
// ---------------------------------------------------------------------------
package cclrn_pkg;

    localparam int MAX_WINDOW   = 15;
    localparam int MAX_CHANNELS = 1024;
    localparam int RING_DEPTH   = 16;
    localparam int RING_AW      = 4;
    localparam int CNT_W        = 11;
    localparam int SUM_W        = 36;
    localparam int LOG_FRAC     = 20;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_ALPHA  = 2'd0;
    localparam logic [1:0] CFG_BETA   = 2'd1;
    localparam logic [1:0] CFG_WINDOW = 2'd2;

    typedef struct packed {
        logic [23:0] alpha;
        logic [15:0] beta;
        logic [3:0]  n;       // effective window size, 1..15
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic [SUM_W-1:0]   sum;
        logic               last;
    } job_t;

    typedef enum logic [2:0] {
        F_IDLE, F_ADD, F_RD, F_SQ, F_SUB
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE, B_MUL0, B_MUL1, B_DIV, B_NORM, B_LOG, B_POW, B_EXP, B_MAG, B_RND, B_DONE
    } back_state_t;

    typedef logic [LOG_FRAC-1:0][31:0] exp_tab_t;

    // floored integer square root, one result bit per pass
    function automatic logic [31:0] isqrt64(input logic [63:0] v);
        logic [63:0] vv;
        logic [63:0] res;
        logic [63:0] b;
        vv  = v;
        res = 64'd0;
        b   = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (vv >= res + b) begin
                vv  = vv - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res[31:0];
    endfunction

    // entry i holds 2^-(2^-(i+1)) in Q0.32, each the root of the one before
    function automatic exp_tab_t exp_table();
        exp_tab_t    t;
        logic [31:0] c;
        c = isqrt64(64'h8000_0000_0000_0000);
        for (int i = 0; i < LOG_FRAC; i++) begin
            t[i] = c;
            c    = isqrt64({c, 32'h0});
        end
        return t;
    endfunction

    localparam exp_tab_t EXP_TAB = exp_table();

endpackage

### rtl/cross_channel_lrn.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cross_channel_lrn: local response normalization across channels
// Streams one pixel's channels and emits each normalized channel.
// ---------------------------------------------------------------------------
// Samples (signed Q8.8) enter one channel per transfer, the final channel of
// a pixel flagged; channel c leaves once channel c+n/2 is in, and the flag
// flushes the rest. The intake takes a sample, adds its square and issues
// each job it can in turn. The arithmetic unit works one job at a time
// through 13 divide, 5 leading-one, 20 log2 squaring and 20 exp2 product
// steps and takes no new job until the result is in the output register.
// A two-entry job queue and an output register let both sides stall apart.
// Window size writes are dropped while a pixel is in progress.
// ---------------------------------------------------------------------------
module cross_channel_lrn import cclrn_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic signed [15:0] s_sample,
    input  wire logic               s_last_channel,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic signed [15:0]      m_value,
    output logic                    m_last,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [23:0]        cfg_wdata
);

    logic [23:0] alpha_reg;
    logic [15:0] beta_reg;
    logic [3:0]  window_reg;
    cfg_t        cfg;
    logic        pixel_open;
    job_t        push_job, pop_job;
    logic        push, pop, q_full, q_valid;

    // effective window: zero reads as one
    assign cfg.alpha = alpha_reg;
    assign cfg.beta  = beta_reg;
    assign cfg.n     = (window_reg == 4'd0) ? 4'd1 : window_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= 24'd1678;
            beta_reg   <= 16'd12288;
            window_reg <= 4'd5;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ALPHA:  alpha_reg <= cfg_wdata;
                CFG_BETA:   beta_reg  <= cfg_wdata[15:0];
                CFG_WINDOW: begin
                    if (!pixel_open) begin
                        window_reg <= cfg_wdata[3:0];
                    end
                end
                default: ;
            endcase
        end
    end

    cclrn_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_sample       (s_sample),
        .s_last_channel (s_last_channel),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .pixel_open     (pixel_open),
        .job            (push_job),
        .job_push       (push),
        .q_full         (q_full)
    );

    cclrn_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_job),
        .not_empty (q_valid)
    );

    cclrn_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .job       (pop_job),
        .job_valid (q_valid),
        .job_pop   (pop),
        .m_value   (m_value),
        .m_last    (m_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

endmodule
`default_nettype wire

### rtl/cclrn_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cclrn_front: sample intake and window bookkeeping
// Stores samples in the ring, keeps the running sum of squares and issues
// one normalization job per channel that becomes ready.
// ---------------------------------------------------------------------------
module cclrn_front import cclrn_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_t               cfg,
    input  wire logic signed [15:0] s_sample,
    input  wire logic               s_last_channel,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    pixel_open,
    output job_t                    job,
    output logic                    job_push,
    input  wire logic               q_full
);

    logic [15:0]         ring_mem [RING_DEPTH];
    front_state_t        state_reg, state_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    recv_reg, recv_next;
    logic [CNT_W-1:0]    emit_reg, emit_next;
    logic [RING_AW-1:0]  ptr_reg, ptr_next;
    logic [30:0]         sq_reg, sq_next;
    logic                flush_reg, flush_next;
    logic signed [15:0]  x_rd_reg, y_rd_reg;
    logic [2:0]          h;
    logic [CNT_W-1:0]    h_cnt;
    logic [CNT_W-1:0]    recv_inc;
    logic [CNT_W-1:0]    emit_inc;
    logic [RING_AW-1:0]  x_idx, y_idx;
    logic signed [31:0]  in_sq, y_sq;
    logic                accept;

    assign h        = cfg.n[3:1];
    assign h_cnt    = CNT_W'(h);
    assign recv_inc = recv_reg + 1'b1;
    assign emit_inc = emit_reg + 1'b1;
    assign x_idx    = ptr_reg - recv_reg[RING_AW-1:0] + emit_reg[RING_AW-1:0];
    assign y_idx    = x_idx - RING_AW'(h);
    assign in_sq    = s_sample * s_sample;
    assign y_sq     = y_rd_reg * y_rd_reg;
    assign accept   = s_valid && s_ready;
    assign pixel_open = (recv_reg != '0);

    assign job.x    = x_rd_reg;
    assign job.sum  = sum_reg;
    assign job.last = flush_reg && (emit_inc == recv_reg);

    // ring write on transfer, registered ring reads
    always_ff @(posedge aclk) begin
        if (accept) begin
            ring_mem[ptr_reg] <= s_sample;
        end
        if (state_reg == F_RD) begin
            x_rd_reg <= ring_mem[x_idx];
            y_rd_reg <= ring_mem[y_idx];
        end
    end

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            sum_reg   <= '0;
            recv_reg  <= '0;
            emit_reg  <= '0;
            ptr_reg   <= '0;
            flush_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            recv_reg  <= recv_next;
            emit_reg  <= emit_next;
            ptr_reg   <= ptr_next;
            flush_reg <= flush_next;
        end
        sq_reg <= sq_next;
    end

    // next state: take sample, add square, then issue jobs one at a time
    always_comb begin
        state_next = state_reg;
        sum_next   = sum_reg;
        recv_next  = recv_reg;
        emit_next  = emit_reg;
        ptr_next   = ptr_reg;
        flush_next = flush_reg;
        sq_next    = sq_reg;
        s_ready    = 1'b0;
        job_push   = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ptr_next   = ptr_reg + 1'b1;
                    recv_next  = recv_inc;
                    flush_next = s_last_channel || (recv_inc >= CNT_W'(MAX_CHANNELS));
                    sq_next    = in_sq[30:0];
                    state_next = F_ADD;
                end
            end
            F_ADD: begin
                sum_next = sum_reg + SUM_W'(sq_reg);
                if (flush_reg || (recv_reg > h_cnt)) begin
                    state_next = F_RD;
                end else begin
                    state_next = F_IDLE;
                end
            end
            F_RD: begin
                state_next = F_SQ;
            end
            F_SQ: begin
                sq_next = y_sq[30:0];
                if (!q_full) begin
                    job_push   = 1'b1;
                    state_next = F_SUB;
                end
            end
            F_SUB: begin
                emit_next = emit_inc;
                if (emit_reg >= h_cnt) begin
                    sum_next = (sum_reg >= SUM_W'(sq_reg)) ? sum_reg - SUM_W'(sq_reg) : '0;
                end
                if (flush_reg && (emit_inc < recv_reg)) begin
                    state_next = F_RD;
                end else begin
                    state_next = F_IDLE;
                    if (flush_reg) begin
                        sum_next   = '0;
                        recv_next  = '0;
                        emit_next  = '0;
                        ptr_next   = '0;
                        flush_next = 1'b0;
                    end
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### rtl/cclrn_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cclrn_queue: two-entry job queue
// Decouples the intake side from the arithmetic side.
// ---------------------------------------------------------------------------
module cclrn_queue import cclrn_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_data,
    output logic      full,
    input  wire logic pop,
    output job_t      pop_data,
    output logic      not_empty
);

    job_t       slot_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = slot_reg[rd_reg];

    // advance pointers and count
    always_comb begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            slot_reg[wr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

### rtl/cclrn_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cclrn_back: normalization datapath
// Computes x * 2^-(beta*log2(1 + alpha/n*sum)) with iterative divide,
// leading-one search, log2 by squaring and exp2 by a constant product.
// ---------------------------------------------------------------------------
module cclrn_back import cclrn_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire cfg_t         cfg,
    input  wire job_t         job,
    input  wire logic         job_valid,
    output logic              job_pop,
    output logic signed [15:0] m_value,
    output logic              m_last,
    output logic              m_valid,
    input  wire logic         m_ready
);

    back_state_t        state_reg, state_next;
    logic signed [15:0] x_reg, x_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               last_reg, last_next;
    logic [59:0]        prod_reg, prod_next;
    logic [51:0]        quot_reg, quot_next;
    logic [3:0]         rem_reg, rem_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [63:0]        d_reg, d_next;
    logic [4:0]         e_reg, e_next;
    logic [30:0]        m_reg, m_next;
    logic [19:0]        frac_reg, frac_next;
    logic [26:0]        p_reg, p_next;
    logic [32:0]        r_reg, r_next;
    logic [48:0]        mag_reg, mag_next;
    logic [15:0]        res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        out_value_reg, out_value_next;
    logic               out_last_reg, out_last_next;

    logic [4:0]         dr;
    logic [51:0]        dq;
    logic [4:0]         amt;
    logic               top_zero;
    logic [63:0]        d_sh;
    logic [61:0]        m_sq;
    logic [31:0]        m_hi;
    logic [40:0]        bl;
    logic [24:0]        log_val;
    logic [64:0]        r_prod;
    logic [15:0]        ax;
    logic [6:0]         k;
    logic [5:0]         sh;
    logic [52:0]        rnd_sum;
    logic [52:0]        rnd_q;
    logic               out_free;

    assign m_value  = out_value_reg;
    assign m_last   = out_last_reg;
    assign m_valid  = out_valid_reg;
    assign out_free = !out_valid_reg || m_ready;

    // four quotient bits per cycle, divisor is the window size
    always_comb begin
        dr = {1'b0, rem_reg};
        dq = quot_reg;
        for (int i = 0; i < 4; i++) begin
            dr = {dr[3:0], dq[51]};
            dq = {dq[50:0], 1'b0};
            if (dr >= {1'b0, cfg.n}) begin
                dr    = dr - {1'b0, cfg.n};
                dq[0] = 1'b1;
            end
        end
    end

    // leading-one search: shift by 16, 8, 4, 2, 1 when the top bits are clear
    assign amt      = 5'd16 >> cnt_reg[2:0];
    assign top_zero = ((d_reg >> (7'd64 - {2'b0, amt})) == 64'd0);
    assign d_sh     = top_zero ? (d_reg << amt) : d_reg;

    assign m_sq    = m_reg * m_reg;
    assign m_hi    = m_sq[61:30];
    assign log_val = {5'd31 - e_reg, frac_reg};
    assign bl      = cfg.beta * log_val;
    assign r_prod  = r_reg * EXP_TAB[cnt_reg];
    assign ax      = x_reg[15] ? 16'(-x_reg) : x_reg;
    assign k       = p_reg[26:20];
    assign sh      = 6'd32 + k[5:0];
    assign rnd_sum = {4'b0, mag_reg} + (53'd1 << (sh - 6'd1));
    assign rnd_q   = rnd_sum >> sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        x_reg         <= x_next;
        sum_reg       <= sum_next;
        last_reg      <= last_next;
        prod_reg      <= prod_next;
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        d_reg         <= d_next;
        e_reg         <= e_next;
        m_reg         <= m_next;
        frac_reg      <= frac_next;
        p_reg         <= p_next;
        r_reg         <= r_next;
        mag_reg       <= mag_next;
        res_reg       <= res_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    // sequence one job through the arithmetic steps
    always_comb begin
        state_next     = state_reg;
        x_next         = x_reg;
        sum_next       = sum_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        m_next         = m_reg;
        frac_next      = frac_reg;
        p_next         = p_reg;
        r_next         = r_reg;
        mag_next       = mag_reg;
        res_next       = res_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_ready;
        job_pop        = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (job_valid) begin
                    job_pop    = 1'b1;
                    x_next     = job.x;
                    sum_next   = job.sum;
                    last_next  = job.last;
                    state_next = B_MUL0;
                end
            end
            B_MUL0: begin
                prod_next  = 60'(42'(cfg.alpha) * 42'(sum_reg[17:0]));
                state_next = B_MUL1;
            end
            B_MUL1: begin
                prod_next  = prod_reg + {42'(cfg.alpha) * 42'(sum_reg[35:18]), 18'd0};
                quot_next  = prod_next[59:8];
                rem_next   = 4'd0;
                cnt_next   = 5'd0;
                state_next = B_DIV;
            end
            B_DIV: begin
                quot_next = dq;
                rem_next  = dr[3:0];
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 5'd12) begin
                    d_next     = {12'd0, dq} + 64'h1_0000_0000;
                    e_next     = 5'd0;
                    cnt_next   = 5'd0;
                    state_next = B_NORM;
                end
            end
            B_NORM: begin
                d_next   = d_sh;
                e_next   = top_zero ? e_reg + amt : e_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd4) begin
                    m_next     = d_sh[63:33];
                    frac_next  = 20'd0;
                    cnt_next   = 5'd0;
                    state_next = B_LOG;
                end
            end
            B_LOG: begin
                if (m_hi[31]) begin
                    m_next    = m_hi[31:1];
                    frac_next = {frac_reg[18:0], 1'b1};
                end else begin
                    m_next    = m_hi[30:0];
                    frac_next = {frac_reg[18:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(LOG_FRAC - 1)) begin
                    cnt_next   = 5'd0;
                    state_next = B_POW;
                end
            end
            B_POW: begin
                p_next     = 27'((41'(bl) + 41'd8192) >> 14);
                r_next     = 33'h1_0000_0000;
                cnt_next   = 5'd0;
                state_next = B_EXP;
            end
            B_EXP: begin
                if (p_reg[5'd19 - cnt_reg]) begin
                    r_next = r_prod[64:32];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(LOG_FRAC - 1)) begin
                    state_next = B_MAG;
                end
            end
            B_MAG: begin
                mag_next   = ax * r_reg;
                state_next = B_RND;
            end
            B_RND: begin
                if (k > 7'd20) begin
                    res_next = 16'd0;
                end else if (x_reg[15]) begin
                    res_next = 16'(-rnd_q[15:0]);
                end else begin
                    res_next = rnd_q[15:0];
                end
                state_next = B_DONE;
            end
            B_DONE: begin
                // hold until the output register is free
                if (out_free) begin
                    out_value_next = res_reg;
                    out_last_next  = last_reg;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

endmodule
`default_nettype wire
